/* hdl/de_trial_vector_mix_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the trial vector mix unit
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef DE_TRIAL_VECTOR_MIX_UNIT_ASSERT_SVH
`define DE_TRIAL_VECTOR_MIX_UNIT_ASSERT_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define DTVM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define DTVM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/dtvm_pkg.sv */
// ----------------------------------------------------------------------------
// dtvm_pkg
// Types, register codes and widths shared by the trial vector mix unit.
// ----------------------------------------------------------------------------
package dtvm_pkg;

	// Strategy codes held in the variant register.
	typedef enum logic [2:0] {
		VAR_RAND_BIN = 3'd0,
		VAR_RAND_EXP = 3'd1,
		VAR_CUR_NONE = 3'd2,
		VAR_CUR_BIN  = 3'd3,
		VAR_CUR_EXP  = 3'd4
	} variant_t;

	// Register indexes on the configuration port (byte address / 4).
	typedef enum logic [1:0] {
		REG_VARIANT = 2'd0,
		REG_CROSS   = 2'd1,
		REG_SCALE   = 2'd2,
		REG_PULL    = 2'd3
	} reg_idx_t;

	localparam int CFG_ADDR_W      = 4;
	localparam int CFG_DATA_W      = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [16:0] CROSS_RESET = 17'd32768;
	localparam logic [17:0] SCALE_RESET = 18'd32768;
	localparam logic [16:0] PULL_RESET  = 17'd32768;

	// Exact difference of two Q15.16 values, and the Q.32 accumulator width.
	localparam int DIFF_W = 33;
	localparam int SUM_W  = 53;

	typedef struct packed {
		variant_t    variant;
		logic [16:0] cross_rate;
		logic [17:0] scale_factor;
		logic [16:0] pull_factor;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] current_value;
		logic signed [31:0] diff_first;
		logic signed [31:0] diff_second;
		logic signed [31:0] base_value;
		logic signed [31:0] lower_bound;
		logic signed [31:0] upper_bound;
		logic        [15:0] random_draw;
		logic               forced_index;
		logic               vector_end;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] child_value;
		logic               took_trial;
		logic               child_end;
	} out_item_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic signed [31:0] cur;
		logic signed [31:0] diff_a;
		logic signed [31:0] diff_b;
		logic signed [31:0] base;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic               take;
		logic               use_cur;
		logic               last;
	} job_t;

	// Push side of the queue.
	typedef struct packed {
		logic push;
		job_t job;
	} push_t;

endpackage

/* hdl/dtvm_front.sv */
// ----------------------------------------------------------------------------
// dtvm_front
// Register file and request classifier: decides per request whether the
// trial value is taken and keeps the exponential crossover stop flag.
// ----------------------------------------------------------------------------
module dtvm_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [dtvm_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [dtvm_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [dtvm_pkg::CFG_DATA_W-1:0]        prdata,
	input  logic                                   in_valid,
	input  dtvm_pkg::in_item_t                     in_data,
	input  logic                                   queue_full,
	output dtvm_pkg::push_t                        push,
	output dtvm_pkg::cfg_t                         cfg
);

	dtvm_pkg::cfg_t       cfg_q;
	logic                 exp_stopped_q;
	logic                 cfg_write;
	dtvm_pkg::reg_idx_t   reg_idx;
	logic                 accept;
	logic                 hit;
	logic                 take;
	logic                 stop_set;

	assign reg_idx   = dtvm_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel & penable & pwrite;
	assign cfg       = cfg_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.variant      <= dtvm_pkg::VAR_RAND_BIN;
			cfg_q.cross_rate   <= dtvm_pkg::CROSS_RESET;
			cfg_q.scale_factor <= dtvm_pkg::SCALE_RESET;
			cfg_q.pull_factor  <= dtvm_pkg::PULL_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				dtvm_pkg::REG_VARIANT: cfg_q.variant <= dtvm_pkg::variant_t'(pwdata[2:0]);
				dtvm_pkg::REG_CROSS:   cfg_q.cross_rate <= pwdata[16:0];
				dtvm_pkg::REG_SCALE:   cfg_q.scale_factor <= pwdata[17:0];
				dtvm_pkg::REG_PULL:    cfg_q.pull_factor <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		prdata = '0;
		case (reg_idx)
			dtvm_pkg::REG_VARIANT: prdata[2:0]  = cfg_q.variant;
			dtvm_pkg::REG_CROSS:   prdata[16:0] = cfg_q.cross_rate;
			dtvm_pkg::REG_SCALE:   prdata[17:0] = cfg_q.scale_factor;
			dtvm_pkg::REG_PULL:    prdata[16:0] = cfg_q.pull_factor;
			default:               prdata       = '0;
		endcase
	end

	// Crossover decision for the incoming request.
	assign accept = in_valid & ~queue_full;
	assign hit    = {1'b0, in_data.random_draw} < cfg_q.cross_rate;

	always_comb begin
		take     = 1'b0;
		stop_set = 1'b0;
		case (cfg_q.variant)
			dtvm_pkg::VAR_RAND_BIN, dtvm_pkg::VAR_CUR_BIN: begin
				take = hit | in_data.forced_index;
			end
			dtvm_pkg::VAR_RAND_EXP, dtvm_pkg::VAR_CUR_EXP: begin
				take     = in_data.forced_index | (~exp_stopped_q & hit);
				stop_set = ~take;
			end
			dtvm_pkg::VAR_CUR_NONE: begin
				take = 1'b1;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	// Sticky stop flag; the end of a vector always clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_stopped_q <= 1'b0;
		end else if (accept) begin
			if (in_data.vector_end) begin
				exp_stopped_q <= 1'b0;
			end else if (stop_set) begin
				exp_stopped_q <= 1'b1;
			end
		end
	end

	// Classified request toward the queue.
	always_comb begin
		push.push        = accept;
		push.job.cur     = in_data.current_value;
		push.job.diff_a  = in_data.diff_first;
		push.job.diff_b  = in_data.diff_second;
		push.job.base    = in_data.base_value;
		push.job.lo      = in_data.lower_bound;
		push.job.hi      = in_data.upper_bound;
		push.job.take    = take;
		push.job.use_cur = (cfg_q.variant inside {dtvm_pkg::VAR_CUR_NONE,
			dtvm_pkg::VAR_CUR_BIN, dtvm_pkg::VAR_CUR_EXP});
		push.job.last    = in_data.vector_end;
	end

endmodule

/* hdl/dtvm_queue.sv */
// ----------------------------------------------------------------------------
// dtvm_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module dtvm_queue #(
	parameter int DEPTH = dtvm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dtvm_pkg::push_t  push,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output dtvm_pkg::job_t   head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	dtvm_pkg::job_t  slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign do_push   = push.push & ~full;
	assign do_pop    = pop & not_empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/dtvm_back.sv */
// ----------------------------------------------------------------------------
// dtvm_back
// Arithmetic pipeline: differences, scaled products, rounding with
// saturation, then bound clamping and the final pick into the output register.
// ----------------------------------------------------------------------------
module dtvm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dtvm_pkg::cfg_t     cfg,
	input  logic               q_not_empty,
	input  dtvm_pkg::job_t     q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output dtvm_pkg::out_item_t out_data
);

	localparam int DW = dtvm_pkg::DIFF_W;
	localparam int SW = dtvm_pkg::SUM_W;
	localparam int FW = DW + 19;
	localparam int KW = DW + 18;
	localparam int RW = SW - 16;

	// Fields that ride along with the arithmetic.
	typedef struct packed {
		logic signed [31:0] cur;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
		logic               take;
		logic               last;
	} side_t;

	logic                  adv;
	logic                  v_s1;
	logic                  v_s2;
	logic                  v_s3;
	logic                  out_valid_q;
	dtvm_pkg::out_item_t   out_q;
	side_t                 side_s1;
	side_t                 side_s2;
	side_t                 side_s3;
	logic signed [DW-1:0]  d_ab_s1;
	logic signed [DW-1:0]  d_bc_s1;
	logic signed [31:0]    lead_s1;
	logic                  use_cur_s1;
	logic signed [FW-1:0]  pf_s2;
	logic signed [KW-1:0]  pk_s2;
	logic signed [31:0]    lead_s2;
	logic signed [31:0]    trial_s3;
	logic signed [SW-1:0]  sum;
	logic signed [RW-1:0]  rounded;
	logic signed [31:0]    sat;
	logic                  lt_lo;
	logic                  gt_hi;
	logic                  lo_gt_hi;
	logic signed [31:0]    clamped;

	// The whole back advances together whenever the output can move.
	assign adv       = ~out_valid_q | ~out_stall;
	assign q_pop     = adv & q_not_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_not_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Stage 1: exact 33-bit differences and the leading term.
	always_ff @(posedge clk) begin
		if (adv) begin
			d_ab_s1    <= {q_head.diff_a[31], q_head.diff_a} - {q_head.diff_b[31], q_head.diff_b};
			d_bc_s1    <= {q_head.base[31], q_head.base} - {q_head.cur[31], q_head.cur};
			lead_s1    <= q_head.use_cur ? q_head.cur : q_head.base;
			use_cur_s1 <= q_head.use_cur;
			side_s1    <= '{cur: q_head.cur, lo: q_head.lo, hi: q_head.hi,
				take: q_head.take, last: q_head.last};
		end
	end

	// Stage 2: F*(a-b) and K*(base-cur), the latter zero unless use_cur is set.
	always_ff @(posedge clk) begin
		if (adv) begin
			pf_s2   <= $signed({1'b0, cfg.scale_factor}) * d_ab_s1;
			pk_s2   <= use_cur_s1 ? $signed({1'b0, cfg.pull_factor}) * d_bc_s1
				: $signed(KW'(0));
			lead_s2 <= lead_s1;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: Q.32 sum, round half up, drop 16 bits, saturate to 32 bits.
	always_comb begin
		sum = {{(SW-48){lead_s2[31]}}, lead_s2, 16'b0}
			+ {{(SW-KW){pk_s2[KW-1]}}, pk_s2}
			+ {{(SW-FW){pf_s2[FW-1]}}, pf_s2}
			+ SW'(32768);
		rounded = sum[SW-1:16];
		if (rounded[RW-1:31] == '0 || rounded[RW-1:31] == '1) begin
			sat = rounded[31:0];
		end else if (rounded[RW-1]) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trial_s3 <= sat;
			side_s3  <= side_s2;
		end
	end

	// Output stage: lower bound first, then upper bound wins, then the pick.
	always_comb begin
		lt_lo    = trial_s3 < side_s3.lo;
		gt_hi    = trial_s3 > side_s3.hi;
		lo_gt_hi = side_s3.lo > side_s3.hi;
		if (lt_lo) begin
			clamped = lo_gt_hi ? side_s3.hi : side_s3.lo;
		end else begin
			clamped = gt_hi ? side_s3.hi : trial_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.child_value <= side_s3.take ? clamped : side_s3.cur;
			out_q.took_trial  <= side_s3.take;
			out_q.child_end   <= side_s3.last;
		end
	end

endmodule

/* hdl/de_trial_vector_mix_unit.sv */
// ----------------------------------------------------------------------------
// de_trial_vector_mix_unit
// Differential evolution trial value with binomial or exponential crossover,
// one decision variable per request.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                     Payload
//  in        sink       in_valid / in_stall           in_data  (in_item_t)
//  out       source     out_valid / out_stall         out_data (out_item_t)
//  config    slave      psel / penable / pready       paddr, pwdata, prdata
//
// One request per cycle is accepted and one result per cycle delivered while
// no stall holds the flow. A result passes through the queue and the
// difference, multiply, rounding and output stages of the back. A stall on
// an offered result freezes the back; the queue keeps taking requests until
// it holds QUEUE_DEPTH of them, then in_stall rises. Reset clears all valid
// flags, the stop flag and queue pointers; config takes defaults; no sweep.
//
module de_trial_vector_mix_unit #(
	parameter int QUEUE_DEPTH = dtvm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dtvm_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [dtvm_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [dtvm_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  dtvm_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output dtvm_pkg::out_item_t                out_data
);

	dtvm_pkg::cfg_t   cfg;
	dtvm_pkg::push_t  push;
	dtvm_pkg::job_t   q_head;
	logic             q_full;
	logic             q_not_empty;
	logic             q_pop;

	// Register accesses always complete in their access cycle.
	assign pready   = 1'b1;
	assign in_stall = q_full;

	dtvm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.queue_full (q_full),
		.push       (push),
		.cfg        (cfg)
	);

	dtvm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	dtvm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

/* hdl/dtvm_checker.sv */
// ----------------------------------------------------------------------------
// dtvm_checker
// Port-level checks of the trial vector mix unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "de_trial_vector_mix_unit_assert.svh"

module dtvm_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dtvm_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [dtvm_pkg::CFG_DATA_W-1:0]    pwdata,
	input  logic [dtvm_pkg::CFG_DATA_W-1:0]    prdata,
	input  logic                               pready,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  dtvm_pkg::out_item_t                out_data
);

	logic [7:0] pending_q;
	logic       in_acc;
	logic       out_acc;
	logic       cross_wr;

	assign in_acc   = in_valid & ~in_stall;
	assign out_acc  = out_valid & ~out_stall;
	assign cross_wr = psel & penable & pwrite & pready
		& (paddr[3:2] == dtvm_pkg::REG_CROSS);

	// Requests accepted and not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// A stalled result stays offered and unchanged.
	`DTVM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data), "stalled result changed or dropped")

	// No result is shown without an outstanding request.
	`DTVM_ASSERT_NOW(a_no_phantom, clk, arst_n, out_valid, pending_q != 8'd0,
		"result offered with no request outstanding")

	// The crossover rate reads back what was written.
	`DTVM_ASSERT_NEXT(a_cross_readback, clk, arst_n, cross_wr,
		paddr[3:2] != dtvm_pkg::REG_CROSS || prdata == {15'd0, $past(pwdata[16:0])},
		"crossover rate readback mismatch")

endmodule

bind de_trial_vector_mix_unit dtvm_checker u_checker (.*);
